// ===== hw/rtl/quadratic_root_solver_top_macros.svh =====
// Assertion macros for the quadratic root solver RTL.
// No dependencies; assertions compile out when SYNTHESIS is defined.
`ifndef QUADRATIC_ROOT_SOLVER_TOP_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define QRS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("qrs assertion failed");
`define QRS_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) pre |=> post) \
    else $error("qrs assertion failed");
`else
`define QRS_ASSERT(lbl, clk, rstn, prop)
`define QRS_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ===== hw/rtl/qrs_pkg.sv =====
// Package for the quadratic root solver: widths, status codes, payload types.
// No dependencies.
package qrs_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 16;

  localparam int ProdW   = 2 * DataWidth;      // |b|^2, |a||c|
  localparam int DiscW   = ProdW + 2;          // discriminant magnitude
  localparam int SqSteps = DiscW / 2;          // one root bit per cell
  localparam int RootW   = SqSteps;
  localparam int SremW   = RootW + 2;
  localparam int NumW    = RootW + 2;          // signed numerator
  localparam int NmagW   = NumW - 1;
  localparam int DvdW    = NmagW + FracBits;   // one quotient bit per cell
  localparam int DenW    = DataWidth + 1;

  localparam logic [2:0] ST_NONE   = 3'd0;
  localparam logic [2:0] ST_ONE    = 3'd1;
  localparam logic [2:0] ST_TWO    = 3'd2;
  localparam logic [2:0] ST_ALL    = 3'd3;
  localparam logic [2:0] ST_NOREAL = 3'd4;

  typedef struct packed {
    logic signed [31:0] coef_quad;
    logic signed [31:0] coef_lin;
    logic signed [31:0] coef_const;
  } qrs_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] root_one;
    logic signed [31:0] root_two;
    logic               overflow;
  } qrs_out_t;

  typedef struct packed {
    logic [2:0]                  status;
    logic                        lin;
    logic signed [DataWidth-1:0] a;
    logic signed [DataWidth-1:0] b;
    logic signed [DataWidth-1:0] c;
  } sq_side_t;

  typedef struct packed {
    logic [DiscW-1:0] rad;
    logic [SremW-1:0] rem;
    logic [RootW-1:0] root;
    sq_side_t         side;
  } sq_cell_t;

  typedef struct packed {
    logic [2:0] status;
    logic       neg1;
    logic       neg2;
  } dv_side_t;

  typedef struct packed {
    logic [DenW-1:0] den;
    logic [DvdW-1:0] dvd1;
    logic [DvdW-1:0] dvd2;
    logic [DenW-1:0] rem1;
    logic [DenW-1:0] rem2;
    logic [DvdW-1:0] q1;
    logic [DvdW-1:0] q2;
    dv_side_t        side;
  } dv_cell_t;

endpackage

// ===== hw/rtl/qrs_sqrt_cell.sv =====
// One digit step of the pipelined integer square root.
// Depends on qrs_pkg.
module qrs_sqrt_cell import qrs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  sq_cell_t data_i,
  output logic     valid_o,
  output sq_cell_t data_o
);

  logic [SremW+1:0] trial_rem;
  logic [SremW+1:0] trial;
  logic             take;
  logic [SremW+1:0] diff;
  sq_cell_t         data_d;
  sq_cell_t         data_q;
  logic             valid_q;

  always_comb begin
    trial_rem = {data_i.rem, data_i.rad[DiscW-1 -: 2]};
    trial     = {2'b00, data_i.root, 2'b01};
    take      = (trial_rem >= trial);
    diff      = trial_rem - trial;
    data_d      = data_i;
    data_d.rad  = {data_i.rad[DiscW-3:0], 2'b00};
    data_d.rem  = take ? diff[SremW-1:0] : trial_rem[SremW-1:0];
    data_d.root = {data_i.root[RootW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/qrs_div_cell.sv =====
// One restoring step for both root divisions, sharing the denominator.
// Depends on qrs_pkg.
module qrs_div_cell import qrs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  dv_cell_t data_i,
  output logic     valid_o,
  output dv_cell_t data_o
);

  logic [DenW:0] t1, t2;
  logic [DenW:0] dif1, dif2;
  logic          ge1, ge2;
  dv_cell_t      data_d;
  dv_cell_t      data_q;
  logic          valid_q;

  always_comb begin
    t1   = {data_i.rem1, data_i.dvd1[DvdW-1]};
    t2   = {data_i.rem2, data_i.dvd2[DvdW-1]};
    ge1  = (t1 >= {1'b0, data_i.den});
    ge2  = (t2 >= {1'b0, data_i.den});
    dif1 = t1 - {1'b0, data_i.den};
    dif2 = t2 - {1'b0, data_i.den};
    data_d      = data_i;
    data_d.dvd1 = {data_i.dvd1[DvdW-2:0], 1'b0};
    data_d.dvd2 = {data_i.dvd2[DvdW-2:0], 1'b0};
    data_d.rem1 = ge1 ? dif1[DenW-1:0] : t1[DenW-1:0];
    data_d.rem2 = ge2 ? dif2[DenW-1:0] : t2[DenW-1:0];
    data_d.q1   = {data_i.q1[DvdW-2:0], ge1};
    data_d.q2   = {data_i.q2[DvdW-2:0], ge2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/quadratic_root_solver_top.sv =====
// Pipeline: input register, product stage, square root cells, divider cells, output register.
// Throughput: one request per cycle; the whole pipeline advances together and
// halts only while the output register holds a result that is not taken.
// Depth is set by the square root cells (33) and the divider cells (50).
// Reset (rst_ni low, asynchronous) empties all stages; no clearing pass.
`include "quadratic_root_solver_top_macros.svh"
module quadratic_root_solver_top import qrs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  qrs_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output qrs_out_t out_data_o
);

  localparam logic [DvdW-1:0] PosMax = DvdW'((64'd1 << (DataWidth - 1)) - 64'd1);
  localparam logic [DvdW-1:0] NegMax = DvdW'(64'd1 << (DataWidth - 1));

  logic en;

  // stage 0: input register
  logic                        v0_q;
  logic signed [DataWidth-1:0] a0_q, b0_q, c0_q;
  // stage 1: products
  logic                        v1_q;
  logic [ProdW-1:0]            bsq1_q, ac1_q;
  logic                        acneg1_q;
  logic signed [DataWidth-1:0] a1_q, b1_q, c1_q;
  logic [DataWidth-1:0]        mag_a, mag_b, mag_c;

  logic [DiscW-1:0] p_ext, bsq_ext, disc;
  logic             disc_lt;
  sq_cell_t         sq_head;

  logic     sq_valid [0:SqSteps];
  sq_cell_t sq_data  [0:SqSteps];
  logic     dv_valid [0:DvdW];
  dv_cell_t dv_data  [0:DvdW];

  sq_side_t               sqs;
  logic signed [NumW-1:0] nb, nc, s_ext, n1, n2;
  logic signed [DenW-1:0] den_s;
  logic [NmagW-1:0]       m1, m2;
  dv_cell_t               dv_head;

  logic                 ovf1, ovf2;
  logic [DataWidth-1:0] r1, r2;
  qrs_out_t             res;
  logic                 out_valid_q;
  qrs_out_t             out_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v0_q        <= in_valid_i;
      v1_q        <= v0_q;
      out_valid_q <= dv_valid[DvdW];
    end
  end

  always_comb begin
    mag_a = a0_q[DataWidth-1] ? (~a0_q + 1'b1) : a0_q;
    mag_b = b0_q[DataWidth-1] ? (~b0_q + 1'b1) : b0_q;
    mag_c = c0_q[DataWidth-1] ? (~c0_q + 1'b1) : c0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a0_q     <= in_data_i.coef_quad;
      b0_q     <= in_data_i.coef_lin;
      c0_q     <= in_data_i.coef_const;
      bsq1_q   <= ProdW'(mag_b) * ProdW'(mag_b);
      ac1_q    <= ProdW'(mag_a) * ProdW'(mag_c);
      acneg1_q <= (a0_q[DataWidth-1] != c0_q[DataWidth-1]) && (c0_q != '0);
      a1_q     <= a0_q;
      b1_q     <= b0_q;
      c1_q     <= c0_q;
      out_q    <= res;
    end
  end

  // discriminant and classification feed the first root cell
  always_comb begin
    p_ext   = {ac1_q, 2'b00};
    bsq_ext = {2'b00, bsq1_q};
    disc_lt = (bsq_ext < p_ext);
    disc    = acneg1_q ? (bsq_ext + p_ext) : (bsq_ext - p_ext);
    sq_head           = '0;
    sq_head.rad       = disc;
    sq_head.side.lin  = (a1_q == '0);
    sq_head.side.a    = a1_q;
    sq_head.side.b    = b1_q;
    sq_head.side.c    = c1_q;
    if (a1_q != '0) begin
      if (!acneg1_q && disc_lt) begin
        sq_head.side.status = ST_NOREAL;
      end else if (disc == '0) begin
        sq_head.side.status = ST_ONE;
      end else begin
        sq_head.side.status = ST_TWO;
      end
    end else if (b1_q != '0) begin
      sq_head.side.status = ST_ONE;
    end else if (c1_q == '0) begin
      sq_head.side.status = ST_ALL;
    end else begin
      sq_head.side.status = ST_NONE;
    end
  end

  assign sq_valid[0] = v1_q;
  assign sq_data[0]  = sq_head;

  for (genvar i = 0; i < SqSteps; i++) begin : g_sq
    qrs_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[i]),
      .data_i  (sq_data[i]),
      .valid_o (sq_valid[i+1]),
      .data_o  (sq_data[i+1])
    );
  end

  // numerators and shared denominator
  always_comb begin
    sqs   = sq_data[SqSteps].side;
    nb    = -NumW'(sqs.b);
    nc    = -NumW'(sqs.c);
    s_ext = NumW'({2'b00, sq_data[SqSteps].root});
    if (sqs.lin) begin
      n1    = nc;
      den_s = DenW'(sqs.b);
    end else begin
      n1    = (sqs.status == ST_TWO) ? (nb + s_ext) : nb;
      den_s = {sqs.a, 1'b0};
    end
    n2 = nb - s_ext;
    m1 = n1[NumW-1] ? NmagW'(-n1) : NmagW'(n1);
    m2 = n2[NumW-1] ? NmagW'(-n2) : NmagW'(n2);
    dv_head             = '0;
    dv_head.den         = den_s[DenW-1] ? DenW'(-den_s) : DenW'(den_s);
    dv_head.dvd1        = {m1, {FracBits{1'b0}}};
    dv_head.dvd2        = {m2, {FracBits{1'b0}}};
    dv_head.side.status = sqs.status;
    dv_head.side.neg1   = n1[NumW-1] != den_s[DenW-1];
    dv_head.side.neg2   = n2[NumW-1] != den_s[DenW-1];
  end

  assign dv_valid[0] = sq_valid[SqSteps];
  assign dv_data[0]  = dv_head;

  for (genvar j = 0; j < DvdW; j++) begin : g_dv
    qrs_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_valid[j]),
      .data_i  (dv_data[j]),
      .valid_o (dv_valid[j+1]),
      .data_o  (dv_data[j+1])
    );
  end

  // saturation and result assembly
  always_comb begin
    if (dv_data[DvdW].side.neg1) begin
      ovf1 = dv_data[DvdW].q1 > NegMax;
      r1   = ovf1 ? -NegMax[DataWidth-1:0] : -dv_data[DvdW].q1[DataWidth-1:0];
    end else begin
      ovf1 = dv_data[DvdW].q1 > PosMax;
      r1   = ovf1 ? PosMax[DataWidth-1:0] : dv_data[DvdW].q1[DataWidth-1:0];
    end
    if (dv_data[DvdW].side.neg2) begin
      ovf2 = dv_data[DvdW].q2 > NegMax;
      r2   = ovf2 ? -NegMax[DataWidth-1:0] : -dv_data[DvdW].q2[DataWidth-1:0];
    end else begin
      ovf2 = dv_data[DvdW].q2 > PosMax;
      r2   = ovf2 ? PosMax[DataWidth-1:0] : dv_data[DvdW].q2[DataWidth-1:0];
    end
    res          = '0;
    res.status   = dv_data[DvdW].side.status;
    case (dv_data[DvdW].side.status)
      ST_ONE: begin
        res.root_one = r1;
        res.overflow = ovf1;
      end
      ST_TWO: begin
        res.root_one = r1;
        res.root_two = r2;
        res.overflow = ovf1 || ovf2;
      end
      default: begin
        res.root_one = '0;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `QRS_ASSERT(a_two_only, clk_i, rst_ni, (out_valid_o && out_data_o.status != ST_TWO) |-> (out_data_o.root_two == '0))
  `QRS_ASSERT(a_noroot_zero, clk_i, rst_ni, (out_valid_o && out_data_o.status != ST_ONE && out_data_o.status != ST_TWO) |-> (out_data_o.root_one == '0 && !out_data_o.overflow))
  `QRS_ASSERT_NEXT(a_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i), $stable(dv_valid[DvdW]))

endmodule
